@@ hw/rtl/cdf_pkg.sv @@
// Shared types, codes and constants of the chunk container deframer.
`timescale 1ns / 1ps

package cdf_pkg;

	localparam int LENGTH_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH      = 2;

	localparam int MIN_VERSION_W  = 31;
	localparam int TOTAL_LENGTH_W = 32;
	localparam int CFG_DATA_W     = 32;
	localparam int CFG_INDEX_W    = 1;

	// register indexes on the write port
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_VERSION  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_LENGTH = 1'b1;

	// header layout: "version" tag, then a 4-byte version word
	localparam int TAG_LEN    = 7;
	localparam int HEADER_LEN = 11;
	localparam int WORD_LEN   = 4;

	// result kinds
	localparam logic [1:0] KIND_NAME = 2'd0;
	localparam logic [1:0] KIND_PATH = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;
	localparam logic [1:0] KIND_MARK = 2'd3;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_SHORT     = 3'd1;
	localparam logic [2:0] ERR_PREFIX    = 3'd2;
	localparam logic [2:0] ERR_VERSION   = 3'd3;
	localparam logic [2:0] ERR_TRUNCATED = 3'd4;

	typedef enum logic [11:0] {
		PH_IDLE    = 12'b0000_0000_0001,
		PH_PREFIX  = 12'b0000_0000_0010,
		PH_VERSION = 12'b0000_0000_0100,
		PH_COUNT   = 12'b0000_0000_1000,
		PH_NLEN    = 12'b0000_0001_0000,
		PH_NAME    = 12'b0000_0010_0000,
		PH_PLEN    = 12'b0000_0100_0000,
		PH_PATH    = 12'b0000_1000_0000,
		PH_DLEN    = 12'b0001_0000_0000,
		PH_DATA    = 12'b0010_0000_0000,
		PH_DONE    = 12'b0100_0000_0000,
		PH_ERROR   = 12'b1000_0000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  byte_value;
		logic [31:0] chunk_number;
		logic        chunk_end;
		logic        file_done;
		logic [2:0]  error_code;
	} out_item_t;

	// ASCII "version", one byte per header position
	function automatic logic [7:0] tag_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0:    r = 8'h76;
			3'd1:    r = 8'h65;
			3'd2:    r = 8'h72;
			3'd3:    r = 8'h73;
			3'd4:    r = 8'h69;
			3'd5:    r = 8'h6f;
			3'd6:    r = 8'h6e;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/cdf_if.sv @@
// Valid/ready channel interfaces for raw bytes and parsed words.
`timescale 1ns / 1ps

interface cdf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface cdf_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  byte_value;
	logic [31:0] chunk_number;
	logic        chunk_end;
	logic        file_done;
	logic [2:0]  error_code;

	modport source (output valid, output kind, output byte_value, output chunk_number,
		output chunk_end, output file_done, output error_code, input ready);
	modport sink (input valid, input kind, input byte_value, input chunk_number,
		input chunk_end, input file_done, input error_code, output ready);
endinterface

@@ hw/rtl/cdf_fifo.sv @@
// Small register queue with valid/ready on both sides.
`timescale 1ns / 1ps

module cdf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/cdf_parse.sv @@
// Byte-serial container parser: header, count, length fields and chunk bodies.
`timescale 1ns / 1ps

module cdf_parse import cdf_pkg::*; #(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  in_item_t                  in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output out_item_t                 out_item,
	input  logic [MIN_VERSION_W-1:0]  min_version,
	input  logic [TOTAL_LENGTH_W-1:0] total_length
);

	phase_t                  phase_q, phase_e, phase_d;
	logic [31:0]             offset_q, offset_e, offset_d;
	logic [LENGTH_WIDTH-1:0] remain_q, remain_e, remain_d;
	logic [31:0]             shift_q, shift_e, shift_d;
	logic [1:0]              wcount_q, wcount_e, wcount_d;
	logic [31:0]             left_q, left_e, left_d;
	logic [31:0]             chunk_q, chunk_e, chunk_d;

	logic                    step;
	logic                    restart;
	logic                    emit;
	logic                    finish;
	logic [7:0]              b;
	logic [31:0]             offset_inc;
	logic [31:0]             word;
	logic [31:0]             left_dec;
	logic [LENGTH_WIDTH-1:0] remain_dec;
	logic                    no_room_word;
	logic                    len_over;
	logic                    len_wide;
	logic                    version_low;

	assign step      = in_valid && out_ready;
	assign in_ready  = out_ready;
	assign out_valid = step && emit;

	always_comb begin
		restart = in_item.frame_start || (phase_q == PH_IDLE);
		if (restart) begin
			phase_e  = (min_version != '0) ? PH_PREFIX : PH_COUNT;
			offset_e = '0;
			remain_e = '0;
			shift_e  = '0;
			wcount_e = '0;
			left_e   = '0;
			chunk_e  = '0;
		end else begin
			phase_e  = phase_q;
			offset_e = offset_q;
			remain_e = remain_q;
			shift_e  = shift_q;
			wcount_e = wcount_q;
			left_e   = left_q;
			chunk_e  = chunk_q;
		end

		b            = in_item.data_byte;
		offset_inc   = offset_e + 32'd1;
		word         = {shift_e[23:0], b};
		left_dec     = left_e - 32'd1;
		remain_dec   = remain_e - 1'b1;
		no_room_word = ({1'b0, offset_e} + 33'(WORD_LEN)) > {1'b0, total_length};
		len_over     = ({1'b0, offset_inc} + {1'b0, word}) > {1'b0, total_length};
		len_wide     = (word >> LENGTH_WIDTH) != 32'd0;
		version_low  = word[31] || (word[30:0] < min_version);

		phase_d  = phase_e;
		offset_d = offset_e;
		remain_d = remain_e;
		shift_d  = shift_e;
		wcount_d = wcount_e;
		left_d   = left_e;
		chunk_d  = chunk_e;
		emit     = 1'b0;
		finish   = 1'b0;

		out_item.kind         = KIND_MARK;
		out_item.byte_value   = 8'd0;
		out_item.chunk_number = chunk_e;
		out_item.chunk_end    = 1'b0;
		out_item.file_done    = 1'b0;
		out_item.error_code   = ERR_NONE;

		case (phase_e)
			PH_PREFIX: begin
				if (offset_e == 32'd0 && total_length < 32'(HEADER_LEN)) begin
					phase_d             = PH_ERROR;
					emit                = 1'b1;
					out_item.error_code = ERR_SHORT;
				end else if (b != tag_byte(offset_e[2:0])) begin
					phase_d             = PH_ERROR;
					emit                = 1'b1;
					out_item.error_code = ERR_PREFIX;
				end else begin
					offset_d = offset_inc;
					if (offset_inc >= 32'(TAG_LEN)) begin
						phase_d  = PH_VERSION;
						wcount_d = '0;
						shift_d  = '0;
					end
				end
			end
			PH_VERSION, PH_COUNT, PH_NLEN, PH_PLEN, PH_DLEN: begin
				if (wcount_e == 2'd0 && phase_e != PH_VERSION && no_room_word) begin
					phase_d             = PH_ERROR;
					emit                = 1'b1;
					out_item.error_code = ERR_TRUNCATED;
				end else begin
					shift_d  = word;
					offset_d = offset_inc;
					if (wcount_e != 2'(WORD_LEN - 1)) begin
						wcount_d = wcount_e + 2'd1;
					end else begin
						wcount_d = '0;
						if (phase_e == PH_VERSION) begin
							if (version_low) begin
								phase_d             = PH_ERROR;
								emit                = 1'b1;
								out_item.error_code = ERR_VERSION;
							end else begin
								phase_d = PH_COUNT;
							end
						end else if (phase_e == PH_COUNT) begin
							left_d                = word;
							chunk_d               = '0;
							out_item.chunk_number = 32'd0;
							if (word == 32'd0) begin
								phase_d            = PH_DONE;
								emit               = 1'b1;
								out_item.file_done = 1'b1;
							end else begin
								phase_d = PH_NLEN;
							end
						end else if (len_wide || len_over) begin
							phase_d             = PH_ERROR;
							emit                = 1'b1;
							out_item.error_code = ERR_TRUNCATED;
						end else begin
							remain_d = word[LENGTH_WIDTH-1:0];
							if (word != 32'd0) begin
								case (phase_e)
									PH_NLEN: phase_d = PH_NAME;
									PH_PLEN: phase_d = PH_PATH;
									default: phase_d = PH_DATA;
								endcase
							end else begin
								// empty field: name and path skip ahead, data closes the chunk
								case (phase_e)
									PH_NLEN: phase_d = PH_PLEN;
									PH_PLEN: phase_d = PH_DLEN;
									default: finish  = 1'b1;
								endcase
							end
						end
					end
				end
			end
			PH_NAME, PH_PATH, PH_DATA: begin
				remain_d            = remain_dec;
				offset_d            = offset_inc;
				emit                = 1'b1;
				out_item.byte_value = b;
				case (phase_e)
					PH_NAME: out_item.kind = KIND_NAME;
					PH_PATH: out_item.kind = KIND_PATH;
					default: out_item.kind = KIND_DATA;
				endcase
				if (remain_dec == '0) begin
					case (phase_e)
						PH_NAME: phase_d = PH_PLEN;
						PH_PATH: phase_d = PH_DLEN;
						default: finish  = 1'b1;
					endcase
				end
			end
			default: begin
				// done, error: bytes are dropped until the next frame start
			end
		endcase

		if (finish) begin
			emit               = 1'b1;
			left_d             = left_dec;
			chunk_d            = chunk_e + 32'd1;
			out_item.chunk_end = 1'b1;
			out_item.file_done = (left_dec == 32'd0);
			phase_d            = (left_dec == 32'd0) ? PH_DONE : PH_NLEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			offset_q <= '0;
			remain_q <= '0;
			shift_q  <= '0;
			wcount_q <= '0;
			left_q   <= '0;
			chunk_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			offset_q <= offset_d;
			remain_q <= remain_d;
			shift_q  <= shift_d;
			wcount_q <= wcount_d;
			left_q   <= left_d;
			chunk_q  <= chunk_d;
		end
	end

endmodule

@@ hw/rtl/chunk_container_deframer.sv @@
// Top level of the chunk container deframer: config registers, queues and parser.
//
//  channel  dir  modport  payload                                   word accepted when
//  rx       in   sink     data_byte[7:0], frame_start               rx.valid & rx.ready
//  tx       out  source   kind, byte_value, chunk_number, chunk_end, tx.valid & tx.ready
//                         file_done, error_code
//  wr_*     in   -        wr_index[0], wr_data[31:0]                wr_en
//
// One byte per cycle sustained while the output queue has room. A byte is
// registered in the input queue, parsed combinationally once it is at the
// queue head, and its result (if any) is registered in the output queue,
// which drives tx. The parser advances only when the output queue has room.
// Both queues hold two words, so either side can stall without throttling
// the other. Reset (arst_n) clears all control state and the config
// registers; there is no clearing pass.
`timescale 1ns / 1ps

module chunk_container_deframer import cdf_pkg::*; #(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	cdf_byte_if.sink               rx,
	cdf_result_if.source           tx,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data
);

	logic [MIN_VERSION_W-1:0]  min_version_q;
	logic [TOTAL_LENGTH_W-1:0] total_length_q;

	in_item_t  rx_item;
	in_item_t  parse_in;
	logic      parse_in_valid;
	logic      parse_in_ready;
	out_item_t parse_out;
	logic      parse_out_valid;
	logic      parse_out_ready;
	out_item_t tx_item;

	// Config writes: min_version keeps its low 31 bits, total_length is live.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_version_q  <= '0;
			total_length_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_MIN_VERSION:  min_version_q  <= wr_data[MIN_VERSION_W-1:0];
				REG_TOTAL_LENGTH: total_length_q <= wr_data[TOTAL_LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	assign rx_item.data_byte   = rx.data_byte;
	assign rx_item.frame_start = rx.frame_start;

	// Front: byte queue decouples the source from parser stalls.
	cdf_fifo #(
		.WIDTH ($bits(in_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_in_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (rx.valid),
		.push_ready (rx.ready),
		.push_data  (rx_item),
		.pop_valid  (parse_in_valid),
		.pop_ready  (parse_in_ready),
		.pop_data   (parse_in)
	);

	// Back: header/chunk state machine, one byte per cycle while the out queue has room.
	cdf_parse #(
		.LENGTH_WIDTH (LENGTH_WIDTH)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (parse_in_valid),
		.in_ready     (parse_in_ready),
		.in_item      (parse_in),
		.out_valid    (parse_out_valid),
		.out_ready    (parse_out_ready),
		.out_item     (parse_out),
		.min_version  (min_version_q),
		.total_length (total_length_q)
	);

	// Result queue: the registered output stage toward the sink.
	cdf_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (parse_out_valid),
		.push_ready (parse_out_ready),
		.push_data  (parse_out),
		.pop_valid  (tx.valid),
		.pop_ready  (tx.ready),
		.pop_data   (tx_item)
	);

	assign tx.kind         = tx_item.kind;
	assign tx.byte_value   = tx_item.byte_value;
	assign tx.chunk_number = tx_item.chunk_number;
	assign tx.chunk_end    = tx_item.chunk_end;
	assign tx.file_done    = tx_item.file_done;
	assign tx.error_code   = tx_item.error_code;

endmodule

@@ dv/cdf_parse_check.sv @@
// Deframer scoreboard: tracks config writes and accepted bytes, predicts result words, compares.
`timescale 1ns / 1ps

module cdf_parse_check import cdf_pkg::*; #(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	cdf_byte_if                    rx,
	cdf_result_if                  tx,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	output int                     fails,
	output int                     pending,
	output int                     words_checked,
	output int                     error_marks,
	output int                     files_done
);

	localparam logic [55:0] TAG = "version";
	localparam int REPORT_MAX = 10;

	// parser state as seen from outside
	phase_t      ph;
	logic [30:0] min_ver;
	logic [31:0] tot_len;
	logic [31:0] offs;
	logic [31:0] remain;
	logic [31:0] shreg;
	logic [1:0]  wcount;
	logic [31:0] left;
	logic [31:0] chunk_idx;
	out_item_t   expected_words[$];

	function automatic out_item_t word_of(input logic [1:0] kind, input logic [7:0] value,
		input logic cend, input logic done, input logic [2:0] err);
		out_item_t w;
		w.kind         = kind;
		w.byte_value   = value;
		w.chunk_number = chunk_idx;
		w.chunk_end    = cend;
		w.file_done    = done;
		w.error_code   = err;
		return w;
	endfunction

	function automatic out_item_t abort(input logic [2:0] err);
		ph = PH_ERROR;
		return word_of(KIND_MARK, 8'h00, 1'b0, 1'b0, err);
	endfunction

	function automatic out_item_t close_chunk(input logic [1:0] kind, input logic [7:0] value);
		out_item_t w;
		left = left - 32'd1;
		w = word_of(kind, value, 1'b1, left == 32'd0, ERR_NONE);
		chunk_idx = chunk_idx + 32'd1;
		ph = (left == 32'd0) ? PH_DONE : PH_NLEN;
		return w;
	endfunction

	// advance the parser by one byte; returns 1 when a result word is due
	function automatic bit parse_byte(input logic [7:0] b, input logic fs, output out_item_t w);
		logic [31:0] wv;
		logic [1:0]  k;
		bit          hit;
		hit = 1'b0;
		w = '0;
		if (fs || ph == PH_IDLE) begin
			offs      = '0;
			remain    = '0;
			shreg     = '0;
			wcount    = '0;
			left      = '0;
			chunk_idx = '0;
			ph = (min_ver != '0) ? PH_PREFIX : PH_COUNT;
		end
		case (ph)
			PH_PREFIX: begin
				if (offs == 0 && tot_len < HEADER_LEN) begin
					hit = 1'b1;
					w = abort(ERR_SHORT);
				end else if (b != TAG[55 - 8 * offs[2:0] -: 8]) begin
					hit = 1'b1;
					w = abort(ERR_PREFIX);
				end else begin
					offs = offs + 32'd1;
					if (offs >= TAG_LEN) begin
						ph = PH_VERSION;
						wcount = '0;
						shreg = '0;
					end
				end
			end
			PH_VERSION, PH_COUNT, PH_NLEN, PH_PLEN, PH_DLEN: begin
				if (wcount == 0 && ph != PH_VERSION &&
					{32'd0, offs} + 64'(WORD_LEN) > {32'd0, tot_len}) begin
					hit = 1'b1;
					w = abort(ERR_TRUNCATED);
				end else begin
					shreg = {shreg[23:0], b};
					offs = offs + 32'd1;
					if (wcount < 2'd3) begin
						wcount = wcount + 2'd1;
					end else begin
						wcount = '0;
						wv = shreg;
						if (ph == PH_VERSION) begin
							if (wv[31] || wv < {1'b0, min_ver}) begin
								hit = 1'b1;
								w = abort(ERR_VERSION);
							end else begin
								ph = PH_COUNT;
							end
						end else if (ph == PH_COUNT) begin
							left = wv;
							chunk_idx = '0;
							if (wv == 0) begin
								ph = PH_DONE;
								hit = 1'b1;
								w = word_of(KIND_MARK, 8'h00, 1'b0, 1'b1, ERR_NONE);
							end else begin
								ph = PH_NLEN;
							end
						end else if ((64'(wv) >> LENGTH_WIDTH) != 0 ||
							{32'd0, offs} + {32'd0, wv} > {32'd0, tot_len}) begin
							hit = 1'b1;
							w = abort(ERR_TRUNCATED);
						end else begin
							remain = wv;
							if (wv != 0) begin
								ph = (ph == PH_NLEN) ? PH_NAME : (ph == PH_PLEN) ? PH_PATH : PH_DATA;
							end else if (ph == PH_DLEN) begin
								hit = 1'b1;
								w = close_chunk(KIND_MARK, 8'h00);
							end else begin
								ph = (ph == PH_NLEN) ? PH_PLEN : PH_DLEN;
							end
						end
					end
				end
			end
			PH_NAME, PH_PATH, PH_DATA: begin
				k = (ph == PH_NAME) ? KIND_NAME : (ph == PH_PATH) ? KIND_PATH : KIND_DATA;
				if (remain != 0)
					remain = remain - 32'd1;
				offs = offs + 32'd1;
				hit = 1'b1;
				if (remain != 0) begin
					w = word_of(k, b, 1'b0, 1'b0, ERR_NONE);
				end else if (ph == PH_DATA) begin
					w = close_chunk(k, b);
				end else begin
					ph = (ph == PH_NAME) ? PH_PLEN : PH_DLEN;
					w = word_of(k, b, 1'b0, 1'b0, ERR_NONE);
				end
			end
			default: ;
		endcase
		return hit;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t got;
		out_item_t want;
		if (!arst_n) begin
			ph            = PH_IDLE;
			min_ver       = '0;
			tot_len       = '0;
			offs          = '0;
			remain        = '0;
			shreg         = '0;
			wcount        = '0;
			left          = '0;
			chunk_idx     = '0;
			expected_words.delete();
			fails         = 0;
			pending       = 0;
			words_checked = 0;
			error_marks   = 0;
			files_done    = 0;
		end else begin
			// outgoing word first: it can never belong to a byte taken at this edge
			if (tx.valid && tx.ready) begin
				got.kind         = tx.kind;
				got.byte_value   = tx.byte_value;
				got.chunk_number = tx.chunk_number;
				got.chunk_end    = tx.chunk_end;
				got.file_done    = tx.file_done;
				got.error_code   = tx.error_code;
				words_checked++;
				if (got.error_code != ERR_NONE)
					error_marks++;
				if (got.file_done)
					files_done++;
				if (expected_words.size() == 0) begin
					fails++;
					if (fails <= REPORT_MAX)
						$display("%0t: unexpected word kind %0d byte %h chunk %0d end %b done %b err %0d",
							$time, got.kind, got.byte_value, got.chunk_number, got.chunk_end,
							got.file_done, got.error_code);
				end else begin
					want = expected_words.pop_front();
					if (got.kind != want.kind || got.byte_value != want.byte_value ||
						got.chunk_number != want.chunk_number || got.chunk_end != want.chunk_end ||
						got.file_done != want.file_done || got.error_code != want.error_code) begin
						fails++;
						if (fails <= REPORT_MAX)
							$display({"%0t: mismatch (expected/actual) kind %0d/%0d byte %h/%h ",
								"chunk %0d/%0d end %b/%b done %b/%b err %0d/%0d"}, $time,
								want.kind, got.kind, want.byte_value, got.byte_value,
								want.chunk_number, got.chunk_number, want.chunk_end, got.chunk_end,
								want.file_done, got.file_done, want.error_code, got.error_code);
					end
				end
			end
			if (wr_en) begin
				case (wr_index)
					REG_MIN_VERSION:  min_ver = wr_data[30:0];
					REG_TOTAL_LENGTH: tot_len = wr_data;
					default: ;
				endcase
			end
			if (rx.valid && rx.ready) begin
				if (parse_byte(rx.data_byte, rx.frame_start, want))
					expected_words.push_back(want);
			end
			pending = expected_words.size();
		end
	end

endmodule

@@ dv/tb_chunk_container_deframer.sv @@
// Testbench top for the chunk container deframer: clock, reset, register writes, stimulus, verdict.
`timescale 1ns / 1ps

module tb_chunk_container_deframer;
	import cdf_pkg::*;

	localparam int RANDOM_BYTES  = 1350;   // random part stops after roughly this many bytes
	localparam int PHASE_BYTES   = 170;    // bytes per register setting in the random part
	localparam int LONG_HOLD     = 300;    // receiver hold-off, long enough to back up both queues
	localparam int SETTLE_CYCLES = 6;      // drain margin after the last expected word
	localparam int CYCLE_LIMIT   = 400000; // watchdog bound on the run length

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic                   clk;
	logic                   arst_n;
	logic                   wr_en;
	logic [CFG_INDEX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0]  wr_data;

	cdf_byte_if   rx_ch ();
	cdf_result_if tx_ch ();

	// scoreboard results
	int check_fails;
	int check_pending;
	int words_checked;
	int error_marks;
	int files_done;

	// stimulus bookkeeping
	int         cycles         = 0;
	int         bytes_sent     = 0;
	int         files_sent     = 0;
	int         settings_used  = 0;
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;
	int         hold_requests  = 0;
	logic [7:0] file_buf[$];

	chunk_container_deframer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx_ch),
		.tx       (tx_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	cdf_parse_check parse_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx            (rx_ch),
		.tx            (tx_ch),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.fails         (check_fails),
		.pending       (check_pending),
		.words_checked (words_checked),
		.error_marks   (error_marks),
		.files_done    (files_done)
	);

	initial begin : clock_gen
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost word ends the run here.
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_chunk_container_deframer failed");
		$finish;
	end

	// Receiver side. Random stalls per the current idling mode; each new hold
	// request pulls ready low for the LONG_HOLD hold-off, counted down here,
	// while the sender keeps offering bytes so the block fills up and drops rx.ready.
	initial begin : result_sink
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		tx_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				tx_ch.ready = 1'b0;
			end else begin
				tx_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Register writes happen only with the block idle.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = value;
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic configure(input logic [30:0] minv, input logic [31:0] tlen);
		write_reg(REG_MIN_VERSION, {1'b0, minv});
		write_reg(REG_TOTAL_LENGTH, tlen);
		settings_used++;
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			IDLE_SEND: begin send_idle_pct = 63; recv_stall_pct = 0;  end
			IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 63; end
			IDLE_BOTH: begin send_idle_pct = 23; recv_stall_pct = 23; end
			default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
		endcase
	endtask

	// One byte, with optional idle cycles ahead of it. Starts and ends at a
	// falling edge; valid stays high so back-to-back bytes have no bubble.
	task automatic send_byte(input logic [7:0] b, input logic fs);
		bit taken;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			rx_ch.valid = 1'b0;
			@(negedge clk);
		end
		rx_ch.valid = 1'b1;
		rx_ch.data_byte = b;
		rx_ch.frame_start = fs;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = rx_ch.ready;
		end
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_buf(input logic fs_first);
		for (int i = 0; i < file_buf.size(); i++)
			send_byte(file_buf[i], fs_first && i == 0);
		files_sent++;
	endtask

	// Drain: every expected word out, then a few cycles for a byte that is
	// still in the input queue and will produce nothing.
	task automatic settle();
		rx_ch.valid = 1'b0;
		while (check_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic push_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			file_buf.push_back(w[8 * i +: 8]);
	endtask

	// Build one container file. Mostly well formed with random content; a
	// minority carries a damaged tag, a low version, a bogus chunk count, an
	// oversized length, a cut-off tail (next file restarts it) or trailing junk.
	task automatic make_file(input logic [30:0] minv);
		int          flaw;
		int          nch;
		int          bad_field;
		int          f;
		int          pos;
		logic [31:0] ver;
		logic [31:0] len;
		file_buf.delete();
		flaw = $urandom_range(0, 99);
		if (minv != 0) begin
			for (int i = 0; i < TAG_LEN; i++)
				file_buf.push_back(tag_byte(3'(i)));
			if (flaw < 4) begin
				pos = $urandom_range(0, TAG_LEN - 1);
				file_buf[pos] = file_buf[pos] ^ 8'(1 << $urandom_range(0, 7));
			end
			if (flaw >= 4 && flaw < 9)
				ver = $urandom_range(0, 1) ? {1'b1, 31'($urandom())} :
					32'($urandom_range(0, minv - 31'd1));
			else if ($urandom_range(0, 3) == 0)
				ver = {1'b0, minv};
			else
				ver = minv + $urandom_range(0, 31'h7FFF_FFFF - minv);
			push_word(ver);
		end
		nch = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
		if (flaw >= 9 && flaw < 12)
			push_word($urandom());
		else
			push_word(nch);
		bad_field = (flaw >= 12 && flaw < 17 && nch > 0) ? $urandom_range(0, 3 * nch - 1) : -1;
		f = 0;
		repeat (3 * nch) begin
			len = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
			if (f == bad_field) begin
				push_word($urandom_range(0, 1) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 3));
			end else begin
				push_word(len);
				repeat (len) file_buf.push_back(8'($urandom()));
			end
			f++;
		end
		if (flaw >= 17 && flaw < 25 && file_buf.size() > 1)
			repeat ($urandom_range(1, file_buf.size() - 1)) void'(file_buf.pop_back());
		else if (flaw >= 25 && flaw < 35)
			repeat ($urandom_range(1, 3)) file_buf.push_back(8'($urandom()));
	endtask

	initial begin : stimulus
		int          p;
		int          random_start;
		int          phase_start;
		logic [30:0] minv;
		logic [31:0] tlen;

		rx_ch.valid = 1'b0;
		rx_ch.data_byte = 8'h00;
		rx_ch.frame_start = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_MIN_VERSION;
		wr_data = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed part ---
		// No header. First byte after reset has no frame_start (idle start);
		// a zero count gives the empty-file marker, the next byte is ignored.
		// Then a restart with count 1 where total_length leaves no room for
		// the name length word: truncated on its first byte.
		configure(31'd0, 32'd4);
		file_buf = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
		send_buf(1'b0);
		file_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h7E};
		send_buf(1'b1);
		settle();

		// zero total length: truncated on the first count byte
		configure(31'd0, 32'd0);
		file_buf = '{8'h80};
		send_buf(1'b1);
		settle();

		// header expected but file shorter than a header; the byte after the
		// error is ignored
		configure(31'h7FFF_FFFF, 32'd10);
		file_buf = '{8'h76, 8'h65};
		send_buf(1'b1);
		settle();

		// bad tag byte, then a negative version against the largest minimum
		configure(31'h7FFF_FFFF, 32'hFFFF_FFFF);
		file_buf = '{8'h76, 8'h65, 8'h58};
		send_buf(1'b1);
		file_buf.delete();
		for (int i = 0; i < TAG_LEN; i++)
			file_buf.push_back(tag_byte(3'(i)));
		push_word(32'h8000_0000);
		send_buf(1'b1);
		settle();

		// --- random part: one register setting and one idling mode per phase ---
		random_start = bytes_sent;
		p = 0;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			case (p % 5)
				0:       minv = 31'd0;
				1:       minv = 31'd1;
				2:       minv = 31'($urandom_range(1, 1000));
				3:       minv = 31'h7FFF_FFFF;
				default: minv = 31'($urandom()) | 31'd1;
			endcase
			case (p % 3)
				0:       tlen = 32'hFFFF_FFFF;
				1:       tlen = 32'($urandom_range(40, 200));
				default: tlen = $urandom();
			endcase
			configure(minv, tlen);
			set_idling(idle_mode_t'(p % 4));
			// back-pressure bursts in two of the phases without sender gaps
			if (p == 0 || p == 4)
				hold_requests++;
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES &&
				bytes_sent - random_start < RANDOM_BYTES) begin
				make_file(minv);
				send_buf(1'b1);
			end
			settle();
			p++;
		end

		$display("Run covered %0d bytes in %0d files under %0d register settings and 4 idling modes.",
			bytes_sent, files_sent, settings_used);
		$display("%0d result words checked: %0d error markers, %0d files completed.",
			words_checked, error_marks, files_done);
		if (check_fails == 0 && check_pending == 0)
			$display("tb_chunk_container_deframer passed");
		else
			$display("tb_chunk_container_deframer failed");
		$finish;
	end

endmodule

@@ chunk_container_deframer.f @@
hw/rtl/cdf_pkg.sv
hw/rtl/cdf_if.sv
hw/rtl/cdf_fifo.sv
hw/rtl/cdf_parse.sv
hw/rtl/chunk_container_deframer.sv
dv/cdf_parse_check.sv
dv/tb_chunk_container_deframer.sv
